@@ hdl/mplm_pkg.sv @@
// ----------------------------------------------------------------------------
// mplm_pkg
// Shared types and constants for the multi-pattern line matcher: node layout,
// input modes, register indexes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package mplm_pkg;

   // field widths
   localparam int KEY_W   = 8;
   localparam int PTR_W   = 11;
   localparam int INDEX_W = 10;
   localparam int MODE_W  = 2;
   localparam int COUNT_W = 32;
   localparam int CSR_IDX_W = 2;

   // default automaton size
   localparam int NODE_COUNT_DEFAULT = 1024;

   // input modes
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXACT_LINE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_CASE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_SELECT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_PATTERN = 2'd3;

   // characters
   localparam logic [KEY_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [KEY_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [KEY_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [KEY_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [KEY_W-1:0] CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // one automaton node as stored in the node table
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PTR_W-1:0] next;
      logic [PTR_W-1:0] sibling;
      logic [PTR_W-1:0] fail;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH_LINE,
      ST_FINISH_END
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic write_node;
      logic scan_begin;
      logic take_sib;
      logic take_fail;
      logic end_hit;
      logic end_miss;
      logic finish;
      logic clear_counts;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_bytes;
      logic finished_eff;
      logic start_is_node;
      logic req_newline;
      logic byte_newline;
      logic run_out;
      logic hit;
      logic sib_node;
      logic fail_node;
   } dp_status_type;

endpackage

@@ hdl/mplm_ram.sv @@
// ----------------------------------------------------------------------------
// mplm_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mplm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mplm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mplm_ctrl
// Sequencer for the matcher: takes commands, steps the node walk one node
// per cycle and schedules line results.
// ----------------------------------------------------------------------------
module mplm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mplm_pkg::MODE_W-1:0]   req_mode,
   input  mplm_pkg::dp_status_type       status,
   output mplm_pkg::dp_cmd_type          cmd,
   output logic                          busy
);
   import mplm_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_SCAN: begin
                     if (!status.finished_eff && status.start_is_node) begin
                        state_in = ST_WALK;
                     end else if (status.req_newline) begin
                        state_in = ST_FINISH_LINE;
                     end
                  end
                  MODE_END: begin
                     if (status.has_bytes) begin
                        state_in = ST_FINISH_END;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WALK: begin
            if (status.run_out || status.hit ||
                (!status.sib_node && !status.fail_node)) begin
               state_in = status.byte_newline ? ST_FINISH_LINE : ST_IDLE;
            end
         end
         ST_FINISH_LINE: state_in = ST_IDLE;
         ST_FINISH_END:  state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_WRITE: cmd.write_node = 1'b1;
                  MODE_SCAN: begin
                     cmd.scan_begin = 1'b1;
                     if (!status.finished_eff && !status.start_is_node) begin
                        cmd.end_miss = 1'b1;
                     end
                  end
                  MODE_END: begin
                     if (!status.has_bytes) begin
                        cmd.clear_counts = 1'b1;
                     end
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_WALK: begin
            if (status.run_out) begin
               cmd.end_miss = 1'b1;
            end else if (status.hit) begin
               cmd.end_hit = 1'b1;
            end else if (status.sib_node) begin
               cmd.take_sib = 1'b1;
            end else begin
               cmd.take_fail = 1'b1;
               cmd.end_miss  = !status.fail_node;
            end
         end
         ST_FINISH_LINE: cmd.finish = 1'b1;
         ST_FINISH_END: begin
            cmd.finish       = 1'b1;
            cmd.clear_counts = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ hdl/mplm_datapath.sv @@
// ----------------------------------------------------------------------------
// mplm_datapath
// Node table, walk pointer, line flags, saturating counters, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module mplm_datapath #(
   parameter int NODE_COUNT = mplm_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mplm_pkg::dp_cmd_type             cmd,
   output mplm_pkg::dp_status_type          status,
   input  logic [mplm_pkg::INDEX_W-1:0]     req_node_index,
   input  logic [mplm_pkg::KEY_W-1:0]       req_node_key,
   input  logic [mplm_pkg::PTR_W-1:0]       req_node_next,
   input  logic [mplm_pkg::PTR_W-1:0]       req_node_sibling,
   input  logic [mplm_pkg::PTR_W-1:0]       req_node_fail,
   input  logic [mplm_pkg::KEY_W-1:0]       req_text_byte,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mplm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic                             csr_wdata,
   output logic                             rsp_valid,
   output logic                             rsp_line_selected,
   output logic [mplm_pkg::COUNT_W-1:0]     rsp_line_number,
   output logic [mplm_pkg::COUNT_W-1:0]     rsp_selected_count
);
   import mplm_pkg::*;

   localparam int AW = $clog2(NODE_COUNT);
   localparam int XW = (AW > PTR_W) ? AW : PTR_W;
   localparam int CW = XW + 1;
   localparam int VW = $clog2(NODE_COUNT + 1);

   function automatic logic ptr_is_node(input logic [PTR_W-1:0] p);
      return CW'(p) < CW'(NODE_COUNT);
   endfunction

   function automatic logic [AW-1:0] ptr_addr(input logic [PTR_W-1:0] p);
      logic [XW-1:0] ext;
      ext = XW'(p);
      return ext[AW-1:0];
   endfunction

   // configuration
   logic exact_ff, fold_ff, invert_ff, empty_ff;
   // line state
   logic [PTR_W-1:0]   current_ff, current_in;
   logic               found_ff, found_in;
   logic               finished_ff, finished_in;
   logic               has_bytes_ff, has_bytes_in;
   logic [COUNT_W-1:0] line_cnt_ff, line_cnt_in;
   logic [COUNT_W-1:0] sel_cnt_ff, sel_cnt_in;
   // walk
   logic [PTR_W-1:0]   t_ff, t_in;
   logic [VW-1:0]      visits_ff, visits_in;
   logic [KEY_W-1:0]   byte_ff;
   // result
   logic               rsp_valid_ff;
   logic               rsp_sel_ff;
   logic [COUNT_W-1:0] rsp_line_ff, rsp_count_ff;

   node_type           rd_node;
   node_type           wr_node;
   logic [NODE_W-1:0]  rd_word;
   logic [XW-1:0]      wr_index_ext;
   logic               wr_en;
   logic [PTR_W-1:0]   start_node;
   logic               hit;
   logic               line_sel;
   logic [COUNT_W-1:0] line_inc, sel_inc;

   // node table
   assign wr_index_ext = XW'(req_node_index);
   assign wr_en = cmd.write_node && (CW'(req_node_index) < CW'(NODE_COUNT));
   assign wr_node = '{key: req_node_key, next: req_node_next,
                      sibling: req_node_sibling, fail: req_node_fail};

   mplm_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index_ext[AW-1:0]),
      .wr_data (wr_node),
      .rd_addr (ptr_addr(t_in)),
      .rd_data (rd_word)
   );

   assign rd_node = node_type'(rd_word);

   // key compare with optional case folding
   always_comb begin
      hit = (rd_node.key == byte_ff);
      if (fold_ff && (byte_ff inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) &&
          (rd_node.key == byte_ff + CASE_OFFSET)) begin
         hit = 1'b1;
      end
   end

   // status to the controller
   assign start_node = has_bytes_ff ? current_ff : '0;

   always_comb begin
      status               = '0;
      status.has_bytes     = has_bytes_ff;
      status.finished_eff  = has_bytes_ff ? finished_ff : empty_ff;
      status.start_is_node = ptr_is_node(start_node);
      status.req_newline   = (req_text_byte == CHAR_NEWLINE);
      status.byte_newline  = (byte_ff == CHAR_NEWLINE);
      status.run_out       = (visits_ff >= VW'(NODE_COUNT));
      status.hit           = hit;
      status.sib_node      = ptr_is_node(rd_node.sibling);
      status.fail_node     = ptr_is_node(rd_node.fail);
   end

   // walk pointer and visit count
   always_comb begin
      t_in      = t_ff;
      visits_in = visits_ff;
      if (cmd.scan_begin) begin
         t_in      = start_node;
         visits_in = '0;
      end else if (cmd.take_sib) begin
         t_in      = rd_node.sibling;
         visits_in = visits_ff + 1'b1;
      end else if (cmd.take_fail) begin
         t_in      = rd_node.fail;
         visits_in = visits_ff + 1'b1;
      end
   end

   // line flags and current node
   always_comb begin
      current_in   = current_ff;
      found_in     = found_ff;
      finished_in  = finished_ff;
      has_bytes_in = has_bytes_ff;
      if (cmd.scan_begin) begin
         has_bytes_in = 1'b1;
         if (!has_bytes_ff) begin
            current_in  = '0;
            found_in    = empty_ff;
            finished_in = empty_ff;
         end
      end
      if (cmd.take_fail && exact_ff) begin
         finished_in = 1'b1;
      end
      if (cmd.end_miss) begin
         current_in = '0;
      end
      if (cmd.end_hit) begin
         current_in = rd_node.next;
         if (!ptr_is_node(rd_node.next)) begin
            found_in    = 1'b1;
            finished_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         has_bytes_in = 1'b0;
      end
   end

   // saturating counters
   assign line_sel = found_ff ^ invert_ff;
   assign line_inc = (line_cnt_ff == COUNT_MAX) ? line_cnt_ff : line_cnt_ff + 1'b1;
   assign sel_inc  = (line_sel && (sel_cnt_ff != COUNT_MAX)) ? sel_cnt_ff + 1'b1
                                                              : sel_cnt_ff;

   always_comb begin
      line_cnt_in = line_cnt_ff;
      sel_cnt_in  = sel_cnt_ff;
      if (cmd.finish) begin
         line_cnt_in = line_inc;
         sel_cnt_in  = sel_inc;
      end
      if (cmd.clear_counts) begin
         line_cnt_in = '0;
         sel_cnt_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exact_ff     <= 1'b0;
         fold_ff      <= 1'b0;
         invert_ff    <= 1'b0;
         empty_ff     <= 1'b0;
         current_ff   <= '0;
         found_ff     <= 1'b0;
         finished_ff  <= 1'b0;
         has_bytes_ff <= 1'b0;
         line_cnt_ff  <= '0;
         sel_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_EXACT_LINE:    exact_ff  <= csr_wdata;
               CSR_FOLD_CASE:     fold_ff   <= csr_wdata;
               CSR_INVERT_SELECT: invert_ff <= csr_wdata;
               CSR_EMPTY_PATTERN: empty_ff  <= csr_wdata;
               default:           exact_ff  <= exact_ff;
            endcase
         end
         current_ff   <= current_in;
         found_ff     <= found_in;
         finished_ff  <= finished_in;
         has_bytes_ff <= has_bytes_in;
         line_cnt_ff  <= line_cnt_in;
         sel_cnt_ff   <= sel_cnt_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   // walk and result payload
   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      visits_ff <= visits_in;
      if (cmd.scan_begin) begin
         byte_ff <= req_text_byte;
      end
      if (cmd.finish) begin
         rsp_sel_ff   <= line_sel;
         rsp_line_ff  <= line_inc;
         rsp_count_ff <= sel_inc;
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_selected  = rsp_sel_ff;
   assign rsp_line_number    = rsp_line_ff;
   assign rsp_selected_count = rsp_count_ff;

endmodule

@@ hdl/multi_pattern_line_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_line_matcher
// Scans a byte stream line by line against a host-loaded pattern automaton
// and reports one result per finished line.
// ----------------------------------------------------------------------------
// Node write: done on acceptance. Scan byte: one node per cycle is visited in
// the sibling/fail walk until a hit, a dead end or the visit limit, then a
// finishing state follows when the byte is a newline; the result strobe follows
// in the next cycle, in which the next command can already be taken. Results
// cannot stall. End of input: a finishing state only with a pending partial line.
// Reset clears configuration, line state and counters; the node table keeps its contents.
module multi_pattern_line_matcher #(
   parameter int NODE_COUNT = mplm_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mplm_pkg::MODE_W-1:0]    req_mode,
   input  logic [mplm_pkg::INDEX_W-1:0]   req_node_index,
   input  logic [mplm_pkg::KEY_W-1:0]     req_node_key,
   input  logic [mplm_pkg::PTR_W-1:0]     req_node_next,
   input  logic [mplm_pkg::PTR_W-1:0]     req_node_sibling,
   input  logic [mplm_pkg::PTR_W-1:0]     req_node_fail,
   input  logic [mplm_pkg::KEY_W-1:0]     req_text_byte,
   output logic                           rsp_valid,
   output logic                           rsp_line_selected,
   output logic [mplm_pkg::COUNT_W-1:0]   rsp_line_number,
   output logic [mplm_pkg::COUNT_W-1:0]   rsp_selected_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mplm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                           csr_wdata
);
   import mplm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   mplm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // datapath
   mplm_datapath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_node_index     (req_node_index),
      .req_node_key       (req_node_key),
      .req_node_next      (req_node_next),
      .req_node_sibling   (req_node_sibling),
      .req_node_fail      (req_node_fail),
      .req_text_byte      (req_text_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_line_selected  (rsp_line_selected),
      .rsp_line_number    (rsp_line_number),
      .rsp_selected_count (rsp_selected_count)
   );

`ifndef SYNTHESIS
   // the result strobe is never held high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // a result only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a finishing cycle");

   // node writes never make the matcher busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_WRITE) |=> !busy)
      else $error("node write did not complete in one cycle");

   // line numbers start at one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0))
      else $error("line number zero reported");

   // a selected line is always counted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_selected) |-> (rsp_selected_count != '0))
      else $error("selected line with zero selected count");
`endif

endmodule
